### rtl/kpt_pkg.sv
// Shared types and constants for the keyed part table.
// Depends on nothing; imported by kpt_cell and keyed_part_table_core.
package kpt_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int KEY_W        = 32;
	localparam int QTY_W        = 32;
	localparam int HDL_W        = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_UPDATE = 2'd2,
		OP_LIST   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_RESP,
		S_LIST
	} state_t;

	// One table entry as it lives in a cell.
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic signed [QTY_W-1:0] qty;
		logic        [HDL_W-1:0] handle;
	} entry_t;

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic compare;
		logic insert;
		logic write_qty;
		logic rotate;
	} cell_ctl_t;

endpackage

### rtl/keyed_part_table_core.sv
// Top level of the keyed part table: command sequencer, output register and
// the chain of kpt_cell instances. Depends on kpt_pkg and kpt_cell.
//
// Usage. Each input word is one command (opcode, part_key, amount,
// name_handle) taken on in_valid high with in_stall low. Results leave as
// words on the output channel (status, out_key, out_handle, out_quantity,
// last), taken on out_valid high with out_stall low; last marks the final
// word of a command.
// Entries are kept in ascending signed key order in a row of cells, except
// while a list rotates them. Insert, search and add-change pass through a
// compare state, in which every cell compares its key with the command key,
// and a response state, in which the matching entry is selected from the
// registered hit flags, the result is formed and the chain is updated (a
// sorted insert shifts the larger entries one cell to the right). A new
// command is taken in the cycle its result enters the output register.
// List emits one word per cycle while the receiver does not stall, straight
// from the head cell, while the valid part of the chain rotates by one
// position; after count rotations the chain is back in order, so a list of
// N entries gives N words (one word with status empty for an empty table).
// Reset clears the entry count, all valid bits and the output valid flag;
// entry contents need no clearing. While the receiver stalls, the output
// word holds and the sequencer waits, so input is stalled unless it is idle.
module keyed_part_table_core #(
	parameter int CAPACITY = kpt_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       opcode,
	input  logic signed [kpt_pkg::KEY_W-1:0] part_key,
	input  logic signed [kpt_pkg::QTY_W-1:0] amount,
	input  logic        [kpt_pkg::HDL_W-1:0] name_handle,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       status,
	output logic signed [kpt_pkg::KEY_W-1:0] out_key,
	output logic        [kpt_pkg::HDL_W-1:0] out_handle,
	output logic signed [kpt_pkg::QTY_W-1:0] out_quantity,
	output logic                             last
);
	import kpt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Command register.
	opcode_t                 op_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [QTY_W-1:0] amt_q;
	logic        [HDL_W-1:0] hdl_q;

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;

	// Output register.
	logic                    out_valid_q;
	status_t                 status_q;
	logic signed [KEY_W-1:0] okey_q;
	logic        [HDL_W-1:0] ohdl_q;
	logic signed [QTY_W-1:0] oqty_q;
	logic                    last_q;

	// Chain wiring.
	entry_t                ent_w [CAPACITY];
	logic [CAPACITY-1:0]   valid_w;
	logic [CAPACITY-1:0]   hit_w;
	logic [CAPACITY-1:0]   ins_w;
	cell_ctl_t             ctl;
	entry_t                new_ent;
	logic signed [QTY_W-1:0] new_qty;

	// Response-cycle logic.
	entry_t                sel_ent;
	logic                  any_hit;
	logic signed [QTY_W:0] sum;
	logic signed [QTY_W-1:0] sat_qty;
	logic                  out_free;
	logic                  done;
	logic                  accept;
	logic                  full;
	logic                  list_last;

	status_t                 st_nxt;
	logic signed [KEY_W-1:0] okey_nxt;
	logic        [HDL_W-1:0] ohdl_nxt;
	logic signed [QTY_W-1:0] oqty_nxt;
	logic                    last_nxt;
	logic                    do_insert;

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign list_last = (count_q == '0) || (idx_q == count_q - CNT_W'(1));

	// A command finishes when its final word moves into the output register.
	assign done   = out_free && ((state_q == S_RESP) || (state_q == S_LIST && list_last));
	assign in_stall = !((state_q == S_IDLE) || done);
	assign accept = in_valid && !in_stall;

	assign new_ent = '{key: key_q, qty: amt_q, handle: hdl_q};
	assign new_qty = sat_qty;

	// At most one cell can hit, so an OR over gated entries selects it.
	always_comb begin
		sel_ent = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_ent = sel_ent | (hit_w[i] ? ent_w[i] : '0);
		end
	end
	assign any_hit = |hit_w;

	// Saturating add of the change to the stored quantity.
	always_comb begin
		sum = {sel_ent.qty[QTY_W-1], sel_ent.qty} + {amt_q[QTY_W-1], amt_q};
		if (sum[QTY_W] != sum[QTY_W-1]) begin
			sat_qty = sum[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
		end else begin
			sat_qty = sum[QTY_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = (opcode == OP_LIST) ? S_LIST : S_LOOK;
				end
			end
			S_LOOK: state_nxt = S_RESP;
			S_RESP, S_LIST: begin
				if (done) begin
					if (accept) begin
						state_nxt = (opcode == OP_LIST) ? S_LIST : S_LOOK;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: cell commands and the next result word.
	always_comb begin
		ctl       = '0;
		do_insert = 1'b0;
		st_nxt    = ST_OK;
		okey_nxt  = key_q;
		ohdl_nxt  = '0;
		oqty_nxt  = '0;
		last_nxt  = 1'b1;
		case (state_q)
			S_LOOK: ctl.compare = 1'b1;
			S_RESP: begin
				if (any_hit) begin
					st_nxt   = (op_q == OP_INSERT) ? ST_DUP : ST_OK;
					ohdl_nxt = sel_ent.handle;
					oqty_nxt = (op_q == OP_UPDATE) ? sat_qty : sel_ent.qty;
					ctl.write_qty = out_free && (op_q == OP_UPDATE);
				end else if (op_q == OP_INSERT) begin
					if (full) begin
						st_nxt = ST_FULL;
					end else begin
						ohdl_nxt   = hdl_q;
						oqty_nxt   = amt_q;
						do_insert  = out_free;
						ctl.insert = out_free;
					end
				end else begin
					st_nxt = ST_NOTFOUND;
				end
			end
			S_LIST: begin
				if (count_q == '0) begin
					st_nxt   = ST_EMPTY;
					okey_nxt = '0;
				end else begin
					okey_nxt   = ent_w[0].key;
					ohdl_nxt   = ent_w[0].handle;
					oqty_nxt   = ent_w[0].qty;
					ctl.rotate = out_free;
				end
				last_nxt = list_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == S_LIST && out_free) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if ((state_q == S_RESP || state_q == S_LIST) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode_t'(opcode);
			key_q <= part_key;
			amt_q <= amount;
			hdl_q <= name_handle;
		end
		if ((state_q == S_RESP || state_q == S_LIST) && out_free) begin
			status_q <= st_nxt;
			okey_q   <= okey_nxt;
			ohdl_q   <= ohdl_nxt;
			oqty_q   <= oqty_nxt;
			last_q   <= last_nxt;
		end
	end

	// The chain. Cell 0 holds the smallest key except during a list rotation,
	// in which the last valid cell takes the head entry.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		kpt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_ent    (new_ent),
			.new_qty    (new_qty),
			.left_ent   ((g == 0) ? new_ent : ent_w[(g == 0) ? 0 : g-1]),
			.left_valid ((g == 0) ? 1'b0 : valid_w[(g == 0) ? 0 : g-1]),
			.left_ins   ((g == 0) ? 1'b0 : ins_w[(g == 0) ? 0 : g-1]),
			.right_ent  ((g == CAPACITY-1) ? ent_w[0] :
			             ent_w[(g == CAPACITY-1) ? 0 : g+1]),
			.right_valid((g == CAPACITY-1) ? 1'b0 :
			             valid_w[(g == CAPACITY-1) ? 0 : g+1]),
			.head_ent   (ent_w[0]),
			.ent        (ent_w[g]),
			.valid      (valid_w[g]),
			.hit        (hit_w[g]),
			.ins        (ins_w[g])
		);
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_key      = okey_q;
	assign out_handle   = ohdl_q;
	assign out_quantity = oqty_q;
	assign last         = last_q;

	// Keys are unique, so a compare never hits in more than one cell.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP |-> $onehot0(hit_w))
		else $error("more than one cell matched the key");

	// The valid bits always agree with the entry count.
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("valid cells disagree with entry count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// A successful insert grows the table by exactly one entry.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not add an entry");

	// A lookup always moves from the compare cycle to the response cycle.
	a_look_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK |=> state_q == S_RESP)
		else $error("compare cycle not followed by response");

endmodule

### rtl/kpt_cell.sv
// One cell of the sorted entry chain: holds one entry and its valid bit.
// Depends on kpt_pkg for the entry and command types.
module kpt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  kpt_pkg::cell_ctl_t ctl,
	input  kpt_pkg::entry_t    new_ent,
	input  logic signed [kpt_pkg::QTY_W-1:0] new_qty,
	input  kpt_pkg::entry_t    left_ent,
	input  logic               left_valid,
	input  logic               left_ins,
	input  kpt_pkg::entry_t    right_ent,
	input  logic               right_valid,
	input  kpt_pkg::entry_t    head_ent,
	output kpt_pkg::entry_t    ent,
	output logic               valid,
	output logic               hit,
	output logic               ins
);
	import kpt_pkg::*;

	entry_t ent_q;
	logic   valid_q;
	logic   hit_q;
	logic   ins_q;

	// Flags from the compare cycle: an exact key match, and whether the new
	// key belongs at or before this position in ascending order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
			ins_q   <= 1'b0;
		end else begin
			if (ctl.compare) begin
				hit_q <= valid_q && (ent_q.key == new_ent.key);
				ins_q <= !valid_q || (new_ent.key < ent_q.key);
			end
			if (ctl.insert && ins_q) begin
				valid_q <= left_ins ? left_valid : 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && ins_q) begin
			ent_q <= left_ins ? left_ent : new_ent;
		end else if (ctl.write_qty && hit_q) begin
			ent_q.qty <= new_qty;
		end else if (ctl.rotate) begin
			ent_q <= right_valid ? right_ent : head_ent;
		end
	end

	assign ent   = ent_q;
	assign valid = valid_q;
	assign hit   = hit_q;
	assign ins   = ins_q;

endmodule

### dv/keyed_part_table_core_tb.sv
// Self-checking testbench for keyed_part_table_core: a directed walk, then random commands,
// checked word by word against an in-bench table predictor or hand-written words.
// Depends on kpt_pkg and the RTL of keyed_part_table_core; needs no other files.
module keyed_part_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kpt_pkg::*;

	localparam int CAPACITY    = CAPACITY_DEF;
	localparam int N_RANDOM    = 450;
	localparam int LONG_HOLD   = 120;        // receiver hold-off, in cycles
	localparam int HOLD_AT     = 200;        // command count that triggers it
	localparam int CALM_TAIL   = 60;         // last commands run without idling
	localparam int DRAIN       = 40;         // cycles waited after the last word
	localparam int MAX_REPORTS = 10;
	// Worst case is roughly 470 commands x 32 words plus the long hold; the limit
	// is several times that.
	localparam int TIMEOUT_NS  = 600_000 * 8;

	localparam logic [31:0] KMIN = 32'h8000_0000;
	localparam logic [31:0] KMAX = 32'h7FFF_FFFF;

	// One result word as it leaves the output channel.
	typedef struct {
		status_t     status;
		logic [31:0] key;
		logic [31:0] handle;
		logic [31:0] qty;
		logic        last;
	} out_word_t;

	// One directed command; known is set where the result is written out by hand.
	typedef struct {
		opcode_t     op;
		logic [31:0] key;
		logic [31:0] amt;
		logic [31:0] hdl;
		bit          known;
		out_word_t   word;
	} cmd_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           opcode;
	logic signed [31:0]   part_key;
	logic signed [31:0]   amount;
	logic        [31:0]   name_handle;
	logic                 out_valid;
	logic                 out_stall;
	logic [2:0]           status;
	logic signed [31:0]   out_key;
	logic        [31:0]   out_handle;
	logic signed [31:0]   out_quantity;
	logic                 last;

	// Predictor state: the stored parts, always kept in ascending signed key order.
	// The block reorders its entries internally, but lookups go by key, so only the
	// order seen by a list matters and a sorted copy gives the same words.
	entry_t    parts[$];
	out_word_t predicted[$];      // words caused by the command just predicted
	out_word_t pending_words[$];  // words still owed by the block, oldest first
	cmd_row_t  directed_cmds[$];

	int  sent;
	int  mismatches;
	int  words_seen;
	int  n_lists;
	int  longest_list;
	int  status_count[5];
	bit  hold_req;
	bit  directed_done;

	keyed_part_table_core #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.part_key     (part_key),
		.amount       (amount),
		.name_handle  (name_handle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_key      (out_key),
		.out_handle   (out_handle),
		.out_quantity (out_quantity),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Reset is applied once and released on a falling edge so that the first rising
	// edge after it sees a settled arst_n.
	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#TIMEOUT_NS;
		$display("timeout: %0d commands sent, %0d words still owed", sent,
			pending_words.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Idling is switched off for every fourth block of fifty commands and for the
	// tail of the run, so that long back-to-back stretches are exercised as well.
	function automatic bit calm();
		return (sent >= N_RANDOM - CALM_TAIL) || (((sent / 50) % 4) == 3);
	endfunction

	function automatic int lookup_part(input logic [31:0] key);
		for (int i = 0; i < parts.size(); i++)
			if (parts[i].key == key)
				return i;
		return -1;
	endfunction

	function automatic out_word_t mk_word(input status_t st, input logic [31:0] key,
			input logic [31:0] hdl, input logic [31:0] qty, input logic lst);
		out_word_t w;
		w.status = st;
		w.key    = key;
		w.handle = hdl;
		w.qty    = qty;
		w.last   = lst;
		return w;
	endfunction

	// Applies one command to the predicted table and fills predicted[] with the
	// words it causes.
	function automatic void predict_command(input opcode_t op, input logic [31:0] key,
			input logic [31:0] amt, input logic [31:0] hdl);
		int                 idx;
		int                 pos;
		entry_t             e;
		logic signed [32:0] sum;
		predicted.delete();
		idx = lookup_part(key);
		case (op)
			OP_INSERT: begin
				if (idx >= 0) begin
					predicted.push_back(mk_word(ST_DUP, key, parts[idx].handle,
						parts[idx].qty, 1'b1));
				end else if (parts.size() >= CAPACITY) begin
					predicted.push_back(mk_word(ST_FULL, key, '0, '0, 1'b1));
				end else begin
					pos = parts.size();
					for (int i = 0; i < parts.size(); i++) begin
						if ($signed(key) < $signed(parts[i].key)) begin
							pos = i;
							break;
						end
					end
					e.key    = key;
					e.qty    = amt;
					e.handle = hdl;
					parts.insert(pos, e);
					predicted.push_back(mk_word(ST_OK, key, hdl, amt, 1'b1));
				end
			end
			OP_SEARCH: begin
				if (idx >= 0)
					predicted.push_back(mk_word(ST_OK, key, parts[idx].handle,
						parts[idx].qty, 1'b1));
				else
					predicted.push_back(mk_word(ST_NOTFOUND, key, '0, '0, 1'b1));
			end
			OP_UPDATE: begin
				if (idx >= 0) begin
					// A 33-bit sum whose top two bits differ has left the 32-bit range.
					sum = $signed({parts[idx].qty[31], parts[idx].qty})
						+ $signed({amt[31], amt});
					if (sum[32] != sum[31])
						parts[idx].qty = sum[32] ? KMIN : KMAX;
					else
						parts[idx].qty = sum[31:0];
					predicted.push_back(mk_word(ST_OK, key, parts[idx].handle,
						parts[idx].qty, 1'b1));
				end else begin
					predicted.push_back(mk_word(ST_NOTFOUND, key, '0, '0, 1'b1));
				end
			end
			default: begin
				if (parts.size() == 0) begin
					predicted.push_back(mk_word(ST_EMPTY, '0, '0, '0, 1'b1));
				end else begin
					for (int i = 0; i < parts.size(); i++)
						predicted.push_back(mk_word(ST_OK, parts[i].key,
							parts[i].handle, parts[i].qty, i == parts.size() - 1));
				end
			end
		endcase
	endfunction

	function automatic cmd_row_t row_pred(input opcode_t op, input logic [31:0] key,
			input logic [31:0] amt, input logic [31:0] hdl);
		cmd_row_t r;
		r.op    = op;
		r.key   = key;
		r.amt   = amt;
		r.hdl   = hdl;
		r.known = 1'b0;
		r.word  = mk_word(ST_OK, '0, '0, '0, 1'b1);
		return r;
	endfunction

	function automatic cmd_row_t row_known(input opcode_t op, input logic [31:0] key,
			input logic [31:0] amt, input logic [31:0] hdl, input status_t st,
			input logic [31:0] okey, input logic [31:0] ohdl, input logic [31:0] oqty);
		cmd_row_t r;
		r       = row_pred(op, key, amt, hdl);
		r.known = 1'b1;
		r.word  = mk_word(st, okey, ohdl, oqty, 1'b1);
		return r;
	endfunction

	function automatic logic [31:0] corner_value(input int sel);
		case (sel)
			0:       return KMIN;
			1:       return KMAX;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			4:       return 32'h0000_0001;
			5:       return KMIN + 32'd1;
			default: return KMAX - 32'd1;
		endcase
	endfunction

	// Offers one command word and holds it until the block takes it. The caller is
	// on a falling edge; the task returns on a falling edge with in_valid still high
	// unless it chose to put in a gap, so a valid that stays high is never dropped
	// and raised in the same step.
	task automatic offer(input opcode_t op, input logic [31:0] key, input logic [31:0] amt,
			input logic [31:0] hdl, input bit known, input out_word_t known_word);
		int gap;
		in_valid    <= 1'b1;
		opcode      <= op;
		part_key    <= key;
		amount      <= amt;
		name_handle <= hdl;
		do
			@(posedge clk);
		while (in_stall);
		// The word is taken at this edge; its results can only show up later, so
		// the expectation is in place before the checker could need it.
		predict_command(op, key, amt, hdl);
		if (known)
			pending_words.push_back(known_word);
		else
			foreach (predicted[i])
				pending_words.push_back(predicted[i]);
		foreach (predicted[i])
			status_count[predicted[i].status]++;
		if (op == OP_LIST) begin
			n_lists++;
			if (predicted.size() > longest_list)
				longest_list = predicted.size();
		end
		sent++;
		if (sent == HOLD_AT)
			hold_req = 1'b1;
		@(negedge clk);
		if (!calm() && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Command source: the directed table first, then random commands.
	initial begin : drive_commands
		opcode_t     op;
		logic [31:0] key;
		logic [31:0] amt;
		logic [31:0] hdl;
		int          r;
		out_word_t   none;
		in_valid      = 1'b0;
		opcode        = OP_INSERT;
		part_key      = '0;
		amount        = '0;
		name_handle   = '0;
		sent          = 0;
		hold_req      = 1'b0;
		directed_done = 1'b0;
		none          = mk_word(ST_OK, '0, '0, '0, 1'b1);

		// Empty table, lookups of missing keys, the key and quantity extremes,
		// a duplicate insert, saturation in both directions and sorted listing.
		directed_cmds.push_back(row_known(OP_LIST, '0, '0, '0, ST_EMPTY, '0, '0, '0));
		directed_cmds.push_back(row_known(OP_SEARCH, '0, 32'd5, 32'd9,
			ST_NOTFOUND, '0, '0, '0));
		directed_cmds.push_back(row_known(OP_UPDATE, KMIN, 32'd1, '0,
			ST_NOTFOUND, KMIN, '0, '0));
		directed_cmds.push_back(row_known(OP_INSERT, KMIN, KMAX, 32'hFFFF_FFFF,
			ST_OK, KMIN, 32'hFFFF_FFFF, KMAX));
		directed_cmds.push_back(row_known(OP_INSERT, KMAX, KMIN, '0,
			ST_OK, KMAX, '0, KMIN));
		directed_cmds.push_back(row_pred(OP_INSERT, '0, '0, 32'h5555_5555));
		directed_cmds.push_back(row_pred(OP_INSERT, 32'hFFFF_FFFF, 32'd100, 32'hAAAA_AAAA));
		directed_cmds.push_back(row_pred(OP_INSERT, 32'd1, -32'sd100, 32'h0000_1234));
		directed_cmds.push_back(row_known(OP_INSERT, '0, 32'd77, 32'd99,
			ST_DUP, '0, 32'h5555_5555, '0));
		directed_cmds.push_back(row_known(OP_UPDATE, KMIN, 32'd1, '0,
			ST_OK, KMIN, 32'hFFFF_FFFF, KMAX));
		directed_cmds.push_back(row_known(OP_UPDATE, KMAX, 32'hFFFF_FFFF, '0,
			ST_OK, KMAX, '0, KMIN));
		directed_cmds.push_back(row_pred(OP_UPDATE, KMIN, KMIN, '0));
		directed_cmds.push_back(row_pred(OP_UPDATE, 32'hFFFF_FFFF, KMAX, '0));
		directed_cmds.push_back(row_pred(OP_SEARCH, 32'hFFFF_FFFF, '0, '0));
		directed_cmds.push_back(row_known(OP_SEARCH, 32'd2, '0, '0,
			ST_NOTFOUND, 32'd2, '0, '0));
		directed_cmds.push_back(row_pred(OP_LIST, 32'd3, 32'd3, 32'd3));
		directed_cmds.push_back(row_pred(OP_UPDATE, 32'd1, KMIN, '0));
		directed_cmds.push_back(row_pred(OP_INSERT, KMAX - 32'd1, 32'd42, 32'h8000_0001));
		directed_cmds.push_back(row_pred(OP_INSERT, KMIN + 32'd1, 32'hFFFF_FFFF, 32'd7));
		directed_cmds.push_back(row_pred(OP_LIST, '0, '0, '0));
		directed_cmds.push_back(row_pred(OP_SEARCH, KMAX, '0, '0));
		directed_cmds.push_back(row_pred(OP_UPDATE, '0, '0, '0));

		@(posedge arst_n);
		@(negedge clk);
		foreach (directed_cmds[i])
			offer(directed_cmds[i].op, directed_cmds[i].key, directed_cmds[i].amt,
				directed_cmds[i].hdl, directed_cmds[i].known, directed_cmds[i].word);
		directed_done = 1'b1;

		// There is no delete, so the table fills as the run goes on: early lists are
		// short, later inserts of new keys meet a full table and lists run 32 long.
		// Half the keys address stored parts so that hits dominate.
		for (int n = 0; n < N_RANDOM; n++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				op = OP_INSERT;
			else if (r < 55)
				op = OP_SEARCH;
			else if (r < 88)
				op = OP_UPDATE;
			else
				op = OP_LIST;
			r = $urandom_range(0, 3);
			if (parts.size() > 0 && r < 2)
				key = parts[$urandom_range(0, parts.size() - 1)].key;
			else if (r == 2)
				key = corner_value($urandom_range(0, 6));
			else
				key = $urandom;
			r = $urandom_range(0, 3);
			if (r == 0)
				amt = corner_value($urandom_range(0, 4));
			else if (r == 1)
				amt = $urandom_range(0, 2000) - 1000;
			else
				amt = $urandom;
			hdl = $urandom;
			offer(op, key, amt, hdl, 1'b0, none);
		end
		in_valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("ran %0d commands (%0d lists, longest %0d entries), %0d words checked",
			sent, n_lists, longest_list, words_seen);
		$display("status mix: ok %0d, duplicate %0d, not found %0d, full %0d, empty %0d",
			status_count[ST_OK], status_count[ST_DUP], status_count[ST_NOTFOUND],
			status_count[ST_FULL], status_count[ST_EMPTY]);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Receiver: random stall bursts, and once, after the trigger point, a long
	// hold-off counted here while the sender keeps offering, so that the block
	// fills up and stalls its input.
	initial begin : drive_stall
		int len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!calm() && $urandom_range(0, 5) == 0) begin
				len = $urandom_range(1, 8);
				out_stall <= 1'b1;
				repeat (len) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Checker: every word taken from the output channel is compared, field by field,
	// with the oldest word still owed. A word with nothing owed is a failure too.
	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected word: status %0d key %h handle %h qty %h last %b",
						status, out_key, out_handle, out_quantity, last);
			end else begin
				want = pending_words.pop_front();
				if (status !== want.status || out_key !== want.key
						|| out_handle !== want.handle || out_quantity !== want.qty
						|| last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("word %0d expected: status %0d key %h handle %h qty %h last %b",
							words_seen, want.status, want.key, want.handle, want.qty,
							want.last);
						$display("word %0d actual:   status %0d key %h handle %h qty %h last %b",
							words_seen, status, out_key, out_handle, out_quantity, last);
					end
				end
			end
		end
	end

endmodule

### sim.f
rtl/kpt_pkg.sv
rtl/kpt_cell.sv
rtl/keyed_part_table_core.sv
dv/keyed_part_table_core_tb.sv
